[src/relr_relocation_expander_top_assert.svh]
// Assertion macros shared by the checker of the relocation expander.
`ifndef RELR_RELOCATION_EXPANDER_TOP_ASSERT_SVH
`define RELR_RELOCATION_EXPANDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RELR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("relr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RELR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("relr assertion failed");

`endif

[src/relr_pkg.sv]
// Package of the relocation expander: sizes, controller types and the bit index encoder.
package relr_pkg;

   localparam int WORD_BITS   = 64;
   localparam int ADDR_BITS   = 64;
   localparam int MAP_BITS    = WORD_BITS - 1;
   localparam int ENTRY_BYTES = WORD_BITS / 8;
   localparam int MAP_STRIDE  = MAP_BITS * ENTRY_BYTES;
   localparam int IDX_BITS    = $clog2(MAP_BITS);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic take_offset;
      logic take_map;
      logic extract;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_map;
      logic anchor;
      logic pend;
      logic map_zero;
      logic out_free;
   } status_type;

   // Encodes a one-hot vector into the position of its set bit.
   function automatic logic [IDX_BITS-1:0] onehot_index(input logic [MAP_BITS-1:0] onehot);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int j = 0; j < MAP_BITS; j++) begin
         if (onehot[j]) begin
            idx = idx | IDX_BITS'(j);
         end
      end
      return idx;
   endfunction

endpackage

[src/relr_ctrl.sv]
// Controller state machine of the relocation expander.
module relr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  relr_pkg::status_type status,
   output relr_pkg::cmd_type    cmd
);

   relr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= relr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         relr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // A bitmap word without an anchor is taken and dropped.
               if (!status.is_map) begin
                  cmd.take_offset = 1'b1;
                  state_in        = relr_pkg::ST_SCAN;
               end else if (status.anchor) begin
                  cmd.take_map = 1'b1;
                  state_in     = relr_pkg::ST_SCAN;
               end
            end
         end
         relr_pkg::ST_SCAN: begin
            cmd.emit    = status.pend && status.out_free;
            cmd.extract = !status.map_zero && (!status.pend || status.out_free);
            cmd.finish  = status.map_zero && (!status.pend || status.out_free);
            if (cmd.finish) begin
               state_in = relr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = relr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/relr_datapath.sv]
// Datapath of the relocation expander: pointer, bitmap scan and output register.
module relr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [relr_pkg::ADDR_BITS-1:0] csr_wr_data,
   input  logic [63:0]                    req_packed_word,
   input  logic                           rsp_ready,
   input  relr_pkg::cmd_type              cmd,
   output relr_pkg::status_type           status,
   output logic                           rsp_valid,
   output logic [relr_pkg::ADDR_BITS-1:0] rsp_patch_address,
   output logic                           rsp_last_of_word
);

   logic [relr_pkg::ADDR_BITS-1:0] base_ff, base_in;
   logic [relr_pkg::ADDR_BITS-1:0] ptr_ff, ptr_in;
   logic                           anchor_ff, anchor_in;
   logic [relr_pkg::MAP_BITS-1:0]  map_ff, map_in;
   logic [relr_pkg::IDX_BITS-1:0]  idx_ff, idx_in;
   logic                           pend_ff, pend_in;
   logic                           big_step_ff, big_step_in;
   logic                           out_vld_ff, out_vld_in;
   logic [relr_pkg::ADDR_BITS-1:0] out_addr_ff, out_addr_in;
   logic                           out_last_ff, out_last_in;

   logic [relr_pkg::MAP_BITS-1:0]  lowest;
   logic [relr_pkg::MAP_BITS-1:0]  map_rest;
   logic [relr_pkg::IDX_BITS-1:0]  lowest_idx;
   logic [relr_pkg::ADDR_BITS-1:0] word_ext;
   logic                           map_zero;
   logic                           out_free;

   assign word_ext   = relr_pkg::ADDR_BITS'(req_packed_word[relr_pkg::WORD_BITS-1:0]);
   assign lowest     = map_ff & (~map_ff + relr_pkg::MAP_BITS'(1));
   assign map_rest   = map_ff & ~lowest;
   assign lowest_idx = relr_pkg::onehot_index(lowest);
   assign map_zero   = (map_ff == '0);
   assign out_free   = !out_vld_ff || rsp_ready;

   assign status.is_map   = req_packed_word[0];
   assign status.anchor   = anchor_ff;
   assign status.pend     = pend_ff;
   assign status.map_zero = map_zero;
   assign status.out_free = out_free;

   always_comb begin
      base_in     = base_ff;
      ptr_in      = ptr_ff;
      anchor_in   = anchor_ff;
      map_in      = map_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      big_step_in = big_step_ff;
      out_vld_in  = out_vld_ff;
      out_addr_in = out_addr_ff;
      out_last_in = out_last_ff;

      if (csr_wr_en) begin
         base_in = csr_wr_data;
      end

      // An offset word runs through the scan as a single pending entry at index zero.
      if (cmd.take_offset) begin
         ptr_in      = base_ff + word_ext;
         idx_in      = '0;
         pend_in     = 1'b1;
         map_in      = '0;
         anchor_in   = 1'b1;
         big_step_in = 1'b0;
      end
      if (cmd.take_map) begin
         map_in      = req_packed_word[relr_pkg::WORD_BITS-1:1];
         pend_in     = 1'b0;
         big_step_in = 1'b1;
      end

      if (cmd.extract) begin
         idx_in  = lowest_idx;
         map_in  = map_rest;
         pend_in = 1'b1;
      end else if (cmd.emit) begin
         pend_in = 1'b0;
      end

      if (cmd.finish) begin
         ptr_in = ptr_ff + (big_step_ff ? relr_pkg::ADDR_BITS'(relr_pkg::MAP_STRIDE)
                                        : relr_pkg::ADDR_BITS'(relr_pkg::ENTRY_BYTES));
      end

      if (cmd.emit) begin
         out_vld_in  = 1'b1;
         out_addr_in = ptr_ff + relr_pkg::ADDR_BITS'(idx_ff)
                              * relr_pkg::ADDR_BITS'(relr_pkg::ENTRY_BYTES);
         out_last_in = map_zero;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         ptr_ff     <= '0;
         anchor_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         base_ff    <= base_in;
         ptr_ff     <= ptr_in;
         anchor_ff  <= anchor_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
      end
      map_ff      <= map_in;
      idx_ff      <= idx_in;
      big_step_ff <= big_step_in;
      out_addr_ff <= out_addr_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_patch_address = out_addr_ff;
   assign rsp_last_of_word  = out_last_ff;

endmodule

[src/relr_relocation_expander_top.sv]
// Top level of the relative relocation expander: controller and datapath.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_packed_word
//   rsp       out        rsp_valid/rsp_ready    rsp_patch_address, rsp_last_of_word
//   csr       in         csr_wr_en              csr_wr_data (load base)
//
// An offset word yields a single patch address; a bitmap word yields one per set bit
// (none when empty, and the word is dropped when no offset has been seen yet).
// The lowest-set-bit unit hands out one bitmap index per cycle to the output register while that register is free.
// Synchronous reset clears the load base, the running pointer, the anchor flag, the pending flag and the output valid.
// A stall on rsp_ready holds the scan until the output register frees up.
module relr_relocation_expander_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [relr_pkg::ADDR_BITS-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [63:0]                    req_packed_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [relr_pkg::ADDR_BITS-1:0] rsp_patch_address,
   output logic                           rsp_last_of_word
);

   relr_pkg::cmd_type    cmd;
   relr_pkg::status_type status;

   relr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   relr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_packed_word   (req_packed_word),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_patch_address (rsp_patch_address),
      .rsp_last_of_word  (rsp_last_of_word)
   );

endmodule

[src/relr_checker.sv]
// Port-level checker of the relocation expander and its bind to the top level.
`include "relr_relocation_expander_top_assert.svh"

module relr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [63:0]                    req_packed_word,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [relr_pkg::ADDR_BITS-1:0] rsp_patch_address,
   input logic                           rsp_last_of_word
);

   logic                           rsp_stall;
   logic [relr_pkg::ADDR_BITS:0]   rsp_word;
   logic                           offset_take;
   logic                           out_open;
   logic                           rsp_final;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_patch_address, rsp_last_of_word};
   assign offset_take = req_valid && req_ready && !req_packed_word[0];
   assign out_open    = !rsp_valid || rsp_ready;
   assign rsp_final   = rsp_valid && rsp_last_of_word;

   // A stalled result word holds its value.
   `RELR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // An offset word keeps the input closed for the following cycle.
   `RELR_ASSERT_NEXT(a_offset_busy, clock, reset, offset_take, !req_ready)

   // An offset word with a free output shows its single, final address after the scan state and the output register.
   `RELR_ASSERT_NEXT(a_offset_result, clock, reset, offset_take && out_open, ##1 rsp_final)

   // No new word is taken while a word still has results to come.
   `RELR_ASSERT_NOW(a_mid_word_closed, clock, reset, rsp_valid && !rsp_last_of_word, !req_ready)

endmodule

bind relr_relocation_expander_top relr_checker u_relr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_packed_word   (req_packed_word),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_patch_address (rsp_patch_address),
   .rsp_last_of_word  (rsp_last_of_word)
);
